// ===== rtl/core/unfd_pkg.sv =====
// unfd_pkg: shared types, constants and field tables for the UBX NAV frame decoder.
// No dependencies; imported by unfd_ctrl, unfd_dp, ubx_nav_frame_decoder and unfd_checker.
`default_nettype none

package unfd_pkg;

  localparam logic [39:0] HDR_PVT = 40'hB5_62_01_07_5C;
  localparam logic [39:0] HDR_DOP = 40'hB5_62_01_04_12;
  localparam logic [7:0]  HDR_LEN_HI = 8'h00;
  localparam logic [2:0]  WIN_FULL = 3'd5;

  localparam logic [6:0] PVT_BYTES = 7'd94;
  localparam logic [6:0] DOP_BYTES = 7'd20;

  localparam logic KIND_PVT = 1'b0;
  localparam logic KIND_DOP = 1'b1;

  localparam logic [4:0] FLD_NUMSV    = 5'd7;
  localparam logic [4:0] FLD_LON      = 5'd8;
  localparam logic [4:0] FLD_LAT      = 5'd9;
  localparam logic [4:0] FLD_HMSL     = 5'd10;
  localparam logic [4:0] FLD_PDOP     = 5'd19;
  localparam logic [4:0] FLD_DLT_BASE = 5'd20;
  localparam logic [4:0] FLD_DOP_LAST = 5'd3;

  localparam logic [1:0] DLT_LON = 2'd0;
  localparam logic [1:0] DLT_LAT = 2'd1;
  localparam logic [1:0] DLT_HGT = 2'd2;

  localparam logic       CFG_MIN_SAT  = 1'b0;
  localparam logic       CFG_MAX_PDOP = 1'b1;
  localparam logic [7:0] MIN_SAT_RST  = 8'd8;
  localparam logic [15:0] MAX_PDOP_RST = 16'd175;

  typedef struct packed {
    logic       win_shift;
    logic       win_clear;
    logic       store;
    logic       pos_clear;
    logic       rd_en;
    logic       take;
    logic       emit;
    logic       emit_delta;
    logic       kind;
    logic [4:0] fld;
    logic [1:0] bidx;
    logic [1:0] didx;
  } cmd_t;

  typedef struct packed {
    logic hit_pvt;
    logic hit_dop;
    logic pos_last;
    logic out_free;
    logic deltas;
  } sts_t;

  function automatic logic [6:0] fld_off(input logic kind, input logic [4:0] idx);
    logic [6:0] off;
    off = 7'd0;
    if (kind == KIND_DOP) begin
      case (idx)
        5'd0:    off = 7'd8;
        5'd1:    off = 7'd10;
        5'd2:    off = 7'd14;
        5'd3:    off = 7'd16;
        default: off = 7'd0;
      endcase
    end else begin
      case (idx)
        5'd0:    off = 7'd4;
        5'd1:    off = 7'd6;
        5'd2:    off = 7'd7;
        5'd3:    off = 7'd8;
        5'd4:    off = 7'd9;
        5'd5:    off = 7'd10;
        5'd6:    off = 7'd20;
        5'd7:    off = 7'd23;
        5'd8:    off = 7'd24;
        5'd9:    off = 7'd28;
        5'd10:   off = 7'd36;
        5'd11:   off = 7'd40;
        5'd12:   off = 7'd44;
        5'd13:   off = 7'd48;
        5'd14:   off = 7'd52;
        5'd15:   off = 7'd56;
        5'd16:   off = 7'd60;
        5'd17:   off = 7'd64;
        5'd18:   off = 7'd68;
        5'd19:   off = 7'd76;
        default: off = 7'd0;
      endcase
    end
    return off;
  endfunction

  // byte count minus one
  function automatic logic [1:0] fld_len(input logic kind, input logic [4:0] idx);
    logic [1:0] len;
    len = 2'd1;
    if (kind == KIND_PVT) begin
      case (idx)
        5'd0:    len = 2'd1;
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7: len = 2'd0;
        5'd19:   len = 2'd1;
        default: len = 2'd3;
      endcase
    end
    return len;
  endfunction

  function automatic logic fld_sgn(input logic kind, input logic [4:0] idx);
    logic sgn;
    sgn = 1'b0;
    if (kind == KIND_PVT) begin
      case (idx)
        5'd8, 5'd9, 5'd10, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17: sgn = 1'b1;
        default: sgn = 1'b0;
      endcase
    end
    return sgn;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/unfd_dp.sv =====
// unfd_dp: header window, payload store, field assembly, home point and result register.
// Depends on unfd_pkg; driven by unfd_ctrl through cmd_t, reports through sts_t.
`default_nettype none

module unfd_dp import unfd_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [4:0]         field_id_o,
  output logic signed [33:0] field_value_o,
  output logic               frame_kind_o,
  output logic               last_field_o
);

  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

  logic [39:0] win_q;
  logic [2:0]  fill_q;
  logic [6:0]  pos_q;
  logic [7:0]  mem [PAYLOAD_DEPTH];
  logic [7:0]  rd_data_q;
  logic [31:0] asm_q;
  logic [7:0]  sats_q;
  logic [31:0] lon_q, lat_q, hgt_q;
  logic [31:0] home_lon_q, home_lat_q, home_hgt_q;
  logic        home_valid_q;
  logic        deltas_q;
  logic [7:0]  min_sat_q;
  logic [15:0] max_pdop_q;
  logic        out_valid_q;
  logic [4:0]  out_id_q;
  logic [33:0] out_value_q;
  logic        out_kind_q;
  logic        out_last_q;

  logic [AW-1:0] wr_addr, rd_addr;
  logic [6:0]    rd_off;
  logic          win_full;
  logic          gate, deltas_d, pdop_emit;
  logic [33:0]   fld_value, dlt_value;
  logic [31:0]   dlt_cur, dlt_home;
  logic          fld_last;

  assign win_full = (fill_q == WIN_FULL) && (rx_byte_i == HDR_LEN_HI);
  assign sts_o.hit_pvt  = win_full && (win_q == HDR_PVT);
  assign sts_o.hit_dop  = win_full && (win_q == HDR_DOP);
  assign sts_o.pos_last = (cmd_i.kind == KIND_DOP) ? (pos_q == DOP_BYTES - 7'd1)
                                                    : (pos_q == PVT_BYTES - 7'd1);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.deltas   = deltas_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      pos_q  <= '0;
    end else begin
      if (cmd_i.win_clear) begin
        win_q  <= '0;
        fill_q <= '0;
      end else if (cmd_i.win_shift) begin
        win_q <= {win_q[31:0], rx_byte_i};
        if (fill_q != WIN_FULL) begin
          fill_q <= fill_q + 3'd1;
        end
      end
      if (cmd_i.pos_clear) begin
        pos_q <= '0;
      end else if (cmd_i.store) begin
        pos_q <= pos_q + 7'd1;
      end
    end
  end

  assign rd_off  = fld_off(cmd_i.kind, cmd_i.fld) + {5'd0, cmd_i.bidx};
  assign rd_addr = AW'(rd_off);
  assign wr_addr = AW'(pos_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      if (cmd_i.bidx == 2'd0) begin
        asm_q <= {24'd0, rd_data_q};
      end else begin
        asm_q[8*cmd_i.bidx +: 8] <= rd_data_q;
      end
    end
    if (cmd_i.emit && cmd_i.kind == KIND_PVT) begin
      if (cmd_i.fld == FLD_NUMSV) begin
        sats_q <= asm_q[7:0];
      end
      if (cmd_i.fld == FLD_LON) begin
        lon_q <= asm_q;
      end
      if (cmd_i.fld == FLD_LAT) begin
        lat_q <= asm_q;
      end
      if (cmd_i.fld == FLD_HMSL) begin
        hgt_q <= asm_q;
      end
    end
  end

  assign gate      = (sats_q > min_sat_q) && (asm_q[15:0] < max_pdop_q);
  assign deltas_d  = gate && home_valid_q;
  assign pdop_emit = cmd_i.emit && (cmd_i.kind == KIND_PVT) && (cmd_i.fld == FLD_PDOP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sat_q    <= MIN_SAT_RST;
      max_pdop_q   <= MAX_PDOP_RST;
      home_valid_q <= 1'b0;
      home_lon_q   <= '0;
      home_lat_q   <= '0;
      home_hgt_q   <= '0;
      deltas_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MIN_SAT) begin
          min_sat_q <= cfg_data_i[7:0];
        end else begin
          max_pdop_q <= cfg_data_i;
        end
      end
      if (pdop_emit) begin
        deltas_q <= deltas_d;
        if (gate && !home_valid_q) begin
          home_valid_q <= 1'b1;
          home_lon_q   <= lon_q;
          home_lat_q   <= lat_q;
          home_hgt_q   <= hgt_q;
        end
      end
    end
  end

  assign fld_value = fld_sgn(cmd_i.kind, cmd_i.fld) ? {{2{asm_q[31]}}, asm_q}
                                                     : {2'b00, asm_q};

  always_comb begin
    case (cmd_i.didx)
      DLT_LON: begin
        dlt_cur  = lon_q;
        dlt_home = home_lon_q;
      end
      DLT_LAT: begin
        dlt_cur  = lat_q;
        dlt_home = home_lat_q;
      end
      default: begin
        dlt_cur  = hgt_q;
        dlt_home = home_hgt_q;
      end
    endcase
  end

  assign dlt_value = {{2{dlt_cur[31]}}, dlt_cur} - {{2{dlt_home[31]}}, dlt_home};

  assign fld_last = (cmd_i.kind == KIND_DOP) ? (cmd_i.fld == FLD_DOP_LAST)
                                              : ((cmd_i.fld == FLD_PDOP) && !deltas_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_delta) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_id_q    <= cmd_i.fld;
      out_value_q <= fld_value;
      out_kind_q  <= cmd_i.kind;
      out_last_q  <= fld_last;
    end else if (cmd_i.emit_delta) begin
      out_id_q    <= FLD_DLT_BASE + {3'd0, cmd_i.didx};
      out_value_q <= dlt_value;
      out_kind_q  <= KIND_PVT;
      out_last_q  <= (cmd_i.didx == DLT_HGT);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_id_o    = out_id_q;
  assign field_value_o = out_value_q;
  assign frame_kind_o  = out_kind_q;
  assign last_field_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/unfd_ctrl.sv =====
// unfd_ctrl: framing and result sequencer for the UBX NAV frame decoder.
// Depends on unfd_pkg; commands unfd_dp through cmd_t and reads sts_t.
`default_nettype none

module unfd_ctrl import unfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic overrun_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_PVT,
    S_DOP,
    S_RD,
    S_TAKE,
    S_EMIT,
    S_CHK,
    S_DELTA
  } state_e;

  state_e     state_q;
  logic       kind_q;
  logic [4:0] fld_q;
  logic [1:0] bidx_q;
  logic [1:0] didx_q;
  logic       accept;
  logic       in_frame;

  assign in_frame   = (state_q == S_PVT) || (state_q == S_DOP);
  assign in_stall_o = !((state_q == S_HUNT) || in_frame);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    cmd_o.fld  = fld_q;
    cmd_o.bidx = bidx_q;
    cmd_o.didx = didx_q;
    case (state_q)
      S_HUNT: begin
        if (accept) begin
          if (overrun_i) begin
            cmd_o.win_clear = 1'b1;
            cmd_o.pos_clear = 1'b1;
          end else if (sts_i.hit_pvt || sts_i.hit_dop) begin
            cmd_o.pos_clear = 1'b1;
          end else begin
            cmd_o.win_shift = 1'b1;
          end
        end
      end
      S_PVT, S_DOP: begin
        if (accept) begin
          if (overrun_i) begin
            cmd_o.win_clear = 1'b1;
            cmd_o.pos_clear = 1'b1;
          end else begin
            cmd_o.store = 1'b1;
            if (sts_i.pos_last) begin
              cmd_o.win_clear = 1'b1;
              cmd_o.pos_clear = 1'b1;
            end
          end
        end
      end
      S_RD:    cmd_o.rd_en = 1'b1;
      S_TAKE:  cmd_o.take = 1'b1;
      S_EMIT:  cmd_o.emit = sts_i.out_free;
      S_DELTA: cmd_o.emit_delta = sts_i.out_free;
      default: cmd_o.rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
      kind_q  <= KIND_PVT;
      fld_q   <= '0;
      bidx_q  <= '0;
      didx_q  <= '0;
    end else begin
      case (state_q)
        S_HUNT: begin
          if (accept && !overrun_i) begin
            if (sts_i.hit_pvt) begin
              state_q <= S_PVT;
              kind_q  <= KIND_PVT;
            end else if (sts_i.hit_dop) begin
              state_q <= S_DOP;
              kind_q  <= KIND_DOP;
            end
          end
        end
        S_PVT, S_DOP: begin
          if (accept) begin
            if (overrun_i) begin
              state_q <= S_HUNT;
            end else if (sts_i.pos_last) begin
              state_q <= S_RD;
              fld_q   <= '0;
              bidx_q  <= '0;
            end
          end
        end
        S_RD: state_q <= S_TAKE;
        S_TAKE: begin
          if (bidx_q == fld_len(kind_q, fld_q)) begin
            state_q <= S_EMIT;
          end else begin
            bidx_q  <= bidx_q + 2'd1;
            state_q <= S_RD;
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (kind_q == KIND_DOP && fld_q == FLD_DOP_LAST) begin
              state_q <= S_HUNT;
            end else if (kind_q == KIND_PVT && fld_q == FLD_PDOP) begin
              state_q <= S_CHK;
            end else begin
              fld_q   <= fld_q + 5'd1;
              bidx_q  <= '0;
              state_q <= S_RD;
            end
          end
        end
        S_CHK: begin
          didx_q  <= DLT_LON;
          state_q <= sts_i.deltas ? S_DELTA : S_HUNT;
        end
        S_DELTA: begin
          if (sts_i.out_free) begin
            if (didx_q == DLT_HGT) begin
              state_q <= S_HUNT;
            end else begin
              didx_q <= didx_q + 2'd1;
            end
          end
        end
        default: state_q <= S_HUNT;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ubx_nav_frame_decoder.sv =====
// ubx_nav_frame_decoder: UBX NAV-PVT / NAV-DOP byte-stream decoder, top level.
// Depends on unfd_pkg, unfd_ctrl and unfd_dp.
//
// Input channel: one received byte per item (rx_byte_i, overrun_i) on in_valid_i/in_stall_o.
// While hunting for a header or storing a frame the block takes one item per cycle.
// Output channel: one decoded field per item on out_valid_o/out_stall_i, held in a single
// result register; last_field_o marks the final result of a frame.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 min_satellites,
// 1 max_pdop) and cfg_data_i; always ready; write only while idle.
// Once the closing byte is stored, each field is fetched from the payload store byte by
// byte, through a read state (S_RD) and a take state (S_TAKE) per byte, and then emitted
// (S_EMIT); the input stalls for this whole result phase, home deltas included.
// Stalls on the output hold the current result and pause the burst.
// Reset: async, active low; clears framing, home point and registers to their defaults.
// An overrun byte drops any partial frame and restarts header search.
`default_nettype none

module ubx_nav_frame_decoder import unfd_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               overrun_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         field_id_o,
  output logic signed [33:0] field_value_o,
  output logic               frame_kind_o,
  output logic               last_field_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  unfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .overrun_i  (overrun_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  unfd_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .field_id_o    (field_id_o),
    .field_value_o (field_value_o),
    .frame_kind_o  (frame_kind_o),
    .last_field_o  (last_field_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/unfd_checker.sv =====
// unfd_checker: port-level checks for ubx_nav_frame_decoder, bound to the top level.
// Depends on unfd_pkg.
`default_nettype none

module unfd_checker import unfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  field_id_o,
  input logic [33:0] field_value_o,
  input logic        frame_kind_o,
  input logic        last_field_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(field_id_o)
      && $stable(field_value_o) && $stable(last_field_o))
    else $error("stalled item changed");

  a_mid_frame_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_field_o |-> in_stall_o)
    else $error("input taken during result burst");

  a_dop_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_DOP |-> field_id_o <= FLD_DOP_LAST)
    else $error("bad dop field id");

  a_dop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_DOP && last_field_o |-> field_id_o == FLD_DOP_LAST)
    else $error("dop frame ended on wrong field");

  a_pvt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_PVT && last_field_o
      |-> field_id_o == FLD_PDOP || field_id_o == FLD_DLT_BASE + 5'd2)
    else $error("pvt frame ended on wrong field");

endmodule

bind ubx_nav_frame_decoder unfd_checker u_unfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .field_id_o    (field_id_o),
  .field_value_o (field_value_o),
  .frame_kind_o  (frame_kind_o),
  .last_field_o  (last_field_o)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for ubx_nav_frame_decoder (UBX NAV-PVT / NAV-DOP decoder).
// Depends on unfd_pkg and the decoder RTL. Frames, noise and overruns go in as byte items;
// decoded fields are checked in order against a built-in byte-level decoder.
`timescale 1ns / 100ps

module tb_top;
  import unfd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS   = 20;

  localparam logic [159:0] PVT_OFF = {8'd76, 8'd68, 8'd64, 8'd60, 8'd56, 8'd52, 8'd48,
                                      8'd44, 8'd40, 8'd36, 8'd28, 8'd24, 8'd23, 8'd20,
                                      8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd4};
  localparam logic [59:0]  PVT_LEN = {3'd2, {11{3'd4}}, {7{3'd1}}, 3'd2};
  localparam logic [19:0]  PVT_SGN = 20'h3E700;
  localparam logic [31:0]  DOP_OFF = {8'd16, 8'd14, 8'd10, 8'd8};

  typedef enum logic [1:0] {MODE_HUNT, MODE_PVT, MODE_DOP} mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       ovr;
  } rx_item_t;

  typedef struct packed {
    logic [4:0]  id;
    logic [33:0] value;
    logic        kind;
    logic        last;
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic overrun_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [4:0] field_id_o;
  logic signed [33:0] field_value_o;
  logic frame_kind_o;
  logic last_field_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  ubx_nav_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .overrun_i     (overrun_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .field_id_o    (field_id_o),
    .field_value_o (field_value_o),
    .frame_kind_o  (frame_kind_o),
    .last_field_o  (last_field_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [39:0] hdr_win = '0;
  logic [2:0]  win_cnt = '0;
  mode_e       mode = MODE_HUNT;
  logic [6:0]  pos = '0;
  logic [7:0]  store [0:127];
  logic        home_ok = 1'b0;
  logic [31:0] home_lon = '0;
  logic [31:0] home_lat = '0;
  logic [31:0] home_hgt = '0;
  logic [7:0]  cfg_min_sat = MIN_SAT_RST;
  logic [15:0] cfg_max_pdop = MAX_PDOP_RST;

  rx_item_t rx_queue [$];
  field_t   pending_fields [$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_mismatch = 0;
  int burst_left = 0;
  int gap_left = 0;
  int cycle_cnt = 0;
  logic [31:0] stall_cnt = '0;
  logic [1:0]  stall_mode = '0;

  function automatic logic [31:0] rd_le(input int off, input int nbytes);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < nbytes; k++) v[8*k +: 8] = store[off + k];
    return v;
  endfunction

  function automatic logic [31:0] pvt_raw(input int id);
    return rd_le(PVT_OFF[id*8 +: 8], PVT_LEN[id*3 +: 3]);
  endfunction

  function automatic logic [33:0] sext34(input logic [31:0] u);
    return {{2{u[31]}}, u};
  endfunction

  function automatic void push_field(input logic [4:0] id, input logic [33:0] value,
                                     input logic kind, input logic last);
    field_t f;
    f.id = id;
    f.value = value;
    f.kind = kind;
    f.last = last;
    pending_fields.push_back(f);
  endfunction

  function automatic void restart_framing();
    hdr_win = '0;
    win_cnt = '0;
    mode = MODE_HUNT;
    pos = '0;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic ovr);
    logic [31:0] raw;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [31:0] hgt;
    logic        with_delta;
    if (ovr) begin
      restart_framing();
      return;
    end
    if (mode == MODE_HUNT) begin
      if (win_cnt >= WIN_FULL && b == HDR_LEN_HI && hdr_win == HDR_PVT) begin
        mode = MODE_PVT;
        pos = '0;
      end else if (win_cnt >= WIN_FULL && b == HDR_LEN_HI && hdr_win == HDR_DOP) begin
        mode = MODE_DOP;
        pos = '0;
      end else begin
        hdr_win = {hdr_win[31:0], b};
        if (win_cnt < WIN_FULL) win_cnt = win_cnt + 3'd1;
      end
      return;
    end
    store[pos] = b;
    pos = pos + 7'd1;
    if (mode == MODE_PVT && pos >= PVT_BYTES) begin
      lon = pvt_raw(FLD_LON);
      lat = pvt_raw(FLD_LAT);
      hgt = pvt_raw(FLD_HMSL);
      with_delta = 1'b0;
      if (pvt_raw(FLD_NUMSV) > cfg_min_sat && pvt_raw(FLD_PDOP) < cfg_max_pdop) begin
        if (!home_ok) begin
          home_ok = 1'b1;
          home_lon = lon;
          home_lat = lat;
          home_hgt = hgt;
        end else begin
          with_delta = 1'b1;
        end
      end
      for (int i = 0; i <= FLD_PDOP; i++) begin
        raw = pvt_raw(i);
        push_field(5'(i), PVT_SGN[i] ? sext34(raw) : {2'b00, raw}, KIND_PVT,
                   !with_delta && i == FLD_PDOP);
      end
      if (with_delta) begin
        push_field(FLD_DLT_BASE + DLT_LON, sext34(lon) - sext34(home_lon), KIND_PVT, 1'b0);
        push_field(FLD_DLT_BASE + DLT_LAT, sext34(lat) - sext34(home_lat), KIND_PVT, 1'b0);
        push_field(FLD_DLT_BASE + DLT_HGT, sext34(hgt) - sext34(home_hgt), KIND_PVT, 1'b1);
      end
      restart_framing();
    end else if (mode != MODE_PVT && pos >= DOP_BYTES) begin
      for (int i = 0; i <= FLD_DOP_LAST; i++) begin
        raw = rd_le(DOP_OFF[i*8 +: 8], 2);
        push_field(5'(i), {18'b0, raw[15:0]}, KIND_DOP, i == FLD_DOP_LAST);
      end
      restart_framing();
    end
  endtask

  task automatic queue_item(input logic [7:0] b, input logic ovr);
    rx_item_t it;
    it.data = b;
    it.ovr = ovr;
    rx_queue.push_back(it);
    n_queued++;
  endtask

  // cut >= 0: send at most that many body bytes, then an overrun item that breaks any partial frame
  task automatic queue_frame(input logic kind, input int fill, input int cut,
                             input logic [7:0] sats, input logic [15:0] pdop,
                             input logic [31:0] lon, input logic [31:0] lat,
                             input logic [31:0] hgt);
    logic [7:0]  body [0:93];
    logic [39:0] hdr;
    int          nbytes;
    hdr = (kind == KIND_PVT) ? HDR_PVT : HDR_DOP;
    nbytes = (kind == KIND_PVT) ? int'(PVT_BYTES) : int'(DOP_BYTES);
    for (int i = 0; i < 94; i++) body[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    if (kind == KIND_PVT) begin
      body[23] = sats;
      {body[77], body[76]} = pdop;
      {body[27], body[26], body[25], body[24]} = lon;
      {body[31], body[30], body[29], body[28]} = lat;
      {body[39], body[38], body[37], body[36]} = hgt;
    end
    for (int i = 4; i >= 0; i--) queue_item(hdr[8*i +: 8], 1'b0);
    queue_item(HDR_LEN_HI, 1'b0);
    if (cut >= 0 && cut < nbytes) nbytes = cut;
    for (int i = 0; i < nbytes; i++) queue_item(body[i], 1'b0);
    if (cut >= 0) queue_item(8'($urandom), 1'b1);
  endtask

  task automatic queue_random(input int n_items);
    int          goal;
    int          pick;
    logic [7:0]  sats;
    logic [15:0] pdop;
    goal = n_queued + n_items;
    while (n_queued < goal) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: sats = cfg_min_sat;
        1: sats = cfg_min_sat + 8'd1;
        2: sats = 8'($urandom);
        default: sats = 8'hFF;
      endcase
      case ($urandom_range(0, 3))
        0: pdop = cfg_max_pdop;
        1: pdop = cfg_max_pdop - 16'd1;
        2: pdop = 16'($urandom);
        default: pdop = '0;
      endcase
      if (pick < 45)
        queue_frame(KIND_PVT, -1, -1, sats, pdop, $urandom, $urandom, $urandom);
      else if (pick < 80)
        queue_frame(KIND_DOP, -1, -1, '0, '0, '0, '0, '0);
      else if (pick < 88)
        queue_frame(pick[0] ? KIND_PVT : KIND_DOP, -1, $urandom_range(0, 93),
                    sats, pdop, $urandom, $urandom, $urandom);
      else
        repeat ($urandom_range(1, 8))
          queue_item($urandom_range(0, 1) ? 8'($urandom) : HDR_PVT[8*$urandom_range(0, 4) +: 8],
                     $urandom_range(0, 11) == 0);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MIN_SAT) cfg_min_sat = data[7:0];
    else cfg_max_pdop = data;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || pending_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver_p
    logic     nxt_valid;
    rx_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i <= '0;
      overrun_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        decode_byte(rx_byte_i, overrun_i);
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rx_queue.size() > 0) begin
          it = rx_queue.pop_front();
          rx_byte_i <= it.data;
          overrun_i <= it.ovr;
          nxt_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor_p
    field_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_fields.size() == 0) begin
          if (n_mismatch < 10)
            $display("unexpected result: id %0d value %0d kind %0d last %0d",
                     field_id_o, field_value_o, frame_kind_o, last_field_o);
          n_mismatch++;
        end else begin
          want = pending_fields.pop_front();
          if (field_id_o !== want.id || field_value_o !== want.value ||
              frame_kind_o !== want.kind || last_field_o !== want.last) begin
            if (n_mismatch < 10)
              $display("mismatch: id %0d value %0d kind %0d last %0d, want %0d %0d %0d %0d",
                       field_id_o, field_value_o, frame_kind_o, last_field_o,
                       want.id, $signed(want.value), want.kind, want.last);
            n_mismatch++;
          end
        end
      end
      stall_cnt = stall_cnt + 32'd1;
      if (stall_cnt[5:0] == 6'd0) stall_mode = 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_cnt[2:0] < 3'd3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(8'hFF, 1'b1);
    queue_item(8'h00, 1'b0);
    queue_frame(KIND_DOP, 8'hFF, -1, '0, '0, '0, '0, '0);
    // satellite count equal to the minimum: no fix
    queue_frame(KIND_PVT, -1, -1, 8'd8, 16'd100, $urandom, $urandom, $urandom);
    queue_frame(KIND_PVT, 8'hFF, -1, 8'd9, 16'd174, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    queue_frame(KIND_PVT, 8'h00, -1, 8'd255, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_FFFF);
    for (int i = 4; i >= 0; i--) queue_item(HDR_PVT[8*i +: 8], 1'b0);
    queue_item(8'h01, 1'b0);
    for (int i = 4; i >= 0; i--) queue_item(HDR_DOP[8*i +: 8], 1'b0);
    queue_item(HDR_LEN_HI, 1'b1);
    drain();

    write_reg(CFG_MIN_SAT, {8'($urandom), 8'($urandom_range(3, 14))});
    write_reg(CFG_MAX_PDOP, 16'($urandom_range(50, 400)));
    queue_random(PHASE_ITEMS);
    drain();

    if (n_mismatch == 0 && pending_fields.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/unfd_pkg.sv
rtl/core/unfd_dp.sv
rtl/core/unfd_ctrl.sv
rtl/core/ubx_nav_frame_decoder.sv
rtl/core/unfd_checker.sv
verif/tb_top.sv
